[sv/dst_rule_time_converter_defines.svh]
// Assertion macros for the daylight-saving time converter.
`ifndef DST_RULE_TIME_CONVERTER_DEFINES_SVH
`define DST_RULE_TIME_CONVERTER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DSTC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dstc: implication check failed");

// Next-cycle implication, disabled during reset.
`define DSTC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dstc: next-cycle check failed");

// Next-cycle implication, checked during reset too.
`define DSTC_ASSERT_RST(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("dstc: reset check failed");

`endif

[sv/dstc_pkg.sv]
// Package: payload types, register indexes and division constants for the converter.
`default_nettype none
package dstc_pkg;

   typedef struct packed {
      logic        operation;
      logic [31:0] time_in;
   } req_type;

   typedef struct packed {
      logic [31:0] time_out;
      logic        in_dst;
   } rsp_type;

   typedef enum logic [1:0] {
      CSR_DST_RULE = 2'd0,
      CSR_STD_RULE = 2'd1,
      CSR_DST_OFF  = 2'd2,
      CSR_STD_OFF  = 2'd3
   } csr_idx_type;

   localparam logic [14:0] DST_RULE_RST = 15'd2248;
   localparam logic [14:0] STD_RULE_RST = 15'd3720;
   localparam logic [10:0] DST_OFF_RST  = 11'd120;
   localparam logic [10:0] STD_OFF_RST  = 11'd60;

   localparam int unsigned NUM_STAGES = 8;

   // floor(x/675) = (x*DIV675_MUL) >> 35 for x < 2^25
   localparam logic [25:0] DIV675_MUL  = 26'd50903317;
   // floor(x/1461) = (x*DIV1461_MUL) >> 27 for x < 2^16
   localparam logic [16:0] DIV1461_MUL = 17'd91868;
   // floor(x/7) = (x*DIV7_MUL) >> 19 for x < 2^16
   localparam logic [16:0] DIV7_MUL    = 17'd74899;

   localparam logic [15:0] EPOCH_FROM_1968 = 16'd731;
   localparam logic [15:0] MAR_2100_FROM_1968 = 16'd48272;
   localparam logic [7:0]  YEAR_2100_IDX = 8'd132;
   localparam logic [3:0]  MONTHS_IN_YEAR = 4'd12;
   localparam logic [3:0]  DAYS_IN_WEEK = 4'd7;

endpackage
`default_nettype wire

[sv/dst_rule_time_converter.sv]
// Pipelined daylight-saving rule time converter between UTC and local seconds.
// One conversion enters per clock when the result side keeps up. An item passes
// eight register stages: seconds to days, day shift and divide by four years,
// year index, rule base day, weekday divide, rule day, change instants, and
// compare and offset. A stall at the output backs up through per-stage valid
// bits, so bubbles are filled before the input stops. Configuration writes are
// taken every cycle and must only be issued while no item is in flight.
`default_nettype none
module dst_rule_time_converter (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire dstc_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output dstc_pkg::rsp_type     rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [1:0]       csr_index,
   input  wire logic [14:0]      csr_wdata
);

   localparam int unsigned NS = dstc_pkg::NUM_STAGES;

   function automatic logic [8:0] cum_days(input logic [3:0] m, input logic leap);
      logic [8:0] d;
      case (m)
         4'd1:    d = 9'd0;
         4'd2:    d = 9'd31;
         4'd3:    d = 9'd59;
         4'd4:    d = 9'd90;
         4'd5:    d = 9'd120;
         4'd6:    d = 9'd151;
         4'd7:    d = 9'd181;
         4'd8:    d = 9'd212;
         4'd9:    d = 9'd243;
         4'd10:   d = 9'd273;
         4'd11:   d = 9'd304;
         default: d = 9'd334;
      endcase
      if (leap && m > 4'd2) begin
         d = d + 9'd1;
      end
      return d;
   endfunction

   // Day number of the first day of the rule's base month (month after, for last-week rules).
   function automatic logic [16:0] rule_base_day(input logic [14:0] rule, input logic [7:0] n);
      logic [3:0]  mon;
      logic [3:0]  m;
      logic [7:0]  ny;
      logic [16:0] y0;
      logic        leap;
      mon = rule[9:6];
      if (mon == 4'd0) begin
         mon = 4'd1;
      end
      if (mon > dstc_pkg::MONTHS_IN_YEAR) begin
         mon = dstc_pkg::MONTHS_IN_YEAR;
      end
      m  = mon;
      ny = n;
      if (rule[2:0] == 3'd0) begin
         if (mon == dstc_pkg::MONTHS_IN_YEAR) begin
            m  = 4'd1;
            ny = n + 8'd1;
         end else begin
            m = mon + 4'd1;
         end
      end
      leap = (ny[1:0] == 2'd0) && (ny != dstc_pkg::YEAR_2100_IDX);
      y0 = 17'(ny) * 17'd365 + 17'((ny + 8'd3) >> 2)
           - 17'(ny > dstc_pkg::YEAR_2100_IDX) - 17'(dstc_pkg::EPOCH_FROM_1968);
      return y0 + 17'(cum_days(m, leap));
   endfunction

   // Rule day: base day moved to the wanted weekday and week.
   function automatic logic [16:0] rule_day(input logic [14:0] rule, input logic [16:0] d0,
                                            input logic [13:0] q7);
      logic [15:0] x;
      logic [2:0]  wd0;
      logic [3:0]  t7;
      logic [3:0]  delta;
      logic [2:0]  w;
      logic [16:0] r;
      x   = d0[15:0] + 16'd4;
      wd0 = 3'(x - 16'(q7) * 16'd7);
      t7  = 4'(rule[5:3]) + dstc_pkg::DAYS_IN_WEEK - (4'(wd0) + 4'd1);
      delta = (t7 >= dstc_pkg::DAYS_IN_WEEK) ? t7 - dstc_pkg::DAYS_IN_WEEK : t7;
      w = (rule[2:0] == 3'd0) ? 3'd1 : rule[2:0];
      r = d0 + 17'(w - 3'd1) * 17'd7 + 17'(delta);
      if (rule[2:0] == 3'd0) begin
         r = r - 17'd7;
      end
      return r;
   endfunction

   logic [14:0]        dst_rule_ff;
   logic [14:0]        std_rule_ff;
   logic signed [10:0] dst_off_ff;
   logic signed [10:0] std_off_ff;
   logic signed [35:0] dsec;
   logic signed [35:0] ssec;

   logic [NS-1:0] v_ff;
   logic [NS-1:0] en;
   logic          op_ff [0:NS-2];
   logic [31:0]   t_ff  [0:NS-2];

   logic [50:0] p1_ff;
   logic [50:0] p1_in;
   logic [15:0] dd_ff;
   logic [15:0] dd_in;
   logic [32:0] p2_ff;
   logic [32:0] p2_in;
   logic [7:0]  n_ff;
   logic [7:0]  n_in;
   logic [16:0] d0_dst_ff, d0_std_ff;
   logic [32:0] p7_dst_ff, p7_std_ff;
   logic [32:0] p7_dst_in, p7_std_in;
   logic [16:0] d0c_dst_ff, d0c_std_ff;
   logic [16:0] dr_dst_ff, dr_std_ff;
   logic signed [35:0] at_dst_ff, at_std_ff;
   logic signed [35:0] at_dst_in, at_std_in;
   logic [31:0] time_out_ff;
   logic [31:0] time_out_in;
   logic        in_dst_ff;
   logic        in_dst_in;

   logic [15:0] days;
   logic [5:0]  q4;
   logic [15:0] r4;
   logic [1:0]  yoff;
   logic signed [35:0] ti;
   logic signed [35:0] off;

   assign csr_ready = 1'b1;
   assign dsec = 36'(dst_off_ff) * 36'sd60;
   assign ssec = 36'(std_off_ff) * 36'sd60;

   always_ff @(posedge clock) begin
      if (reset) begin
         dst_rule_ff <= dstc_pkg::DST_RULE_RST;
         std_rule_ff <= dstc_pkg::STD_RULE_RST;
         dst_off_ff  <= dstc_pkg::DST_OFF_RST;
         std_off_ff  <= dstc_pkg::STD_OFF_RST;
      end else if (csr_valid) begin
         case (dstc_pkg::csr_idx_type'(csr_index))
            dstc_pkg::CSR_DST_RULE: dst_rule_ff <= csr_wdata;
            dstc_pkg::CSR_STD_RULE: std_rule_ff <= csr_wdata;
            dstc_pkg::CSR_DST_OFF:  dst_off_ff  <= csr_wdata[10:0];
            dstc_pkg::CSR_STD_OFF:  std_off_ff  <= csr_wdata[10:0];
            default: ;
         endcase
      end
   end

   // stage enables: a stage loads when empty or when its successor loads
   always_comb begin
      en[NS-1] = !v_ff[NS-1] || rsp_ready;
      for (int i = NS - 2; i >= 0; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = v_ff[NS-1];
   assign rsp_data  = '{time_out: time_out_ff, in_dst: in_dst_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= req_valid;
         end
         for (int i = 1; i < NS; i++) begin
            if (en[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         op_ff[0] <= req_data.operation;
         t_ff[0]  <= req_data.time_in;
      end
      for (int i = 1; i < NS - 1; i++) begin
         if (en[i]) begin
            op_ff[i] <= op_ff[i-1];
            t_ff[i]  <= t_ff[i-1];
         end
      end
   end

   // stage 0: seconds to days
   assign p1_in = 51'(req_data.time_in[31:7]) * 51'(dstc_pkg::DIV675_MUL);

   // stage 1: days from 1968 with a phantom Feb 29 2100, then /1461
   assign days = p1_ff[50:35];
   always_comb begin
      dd_in = days + dstc_pkg::EPOCH_FROM_1968;
      if (dd_in >= dstc_pkg::MAR_2100_FROM_1968) begin
         dd_in = dd_in + 16'd1;
      end
   end
   assign p2_in = 33'(dd_in) * 33'(dstc_pkg::DIV1461_MUL);

   // stage 2: year index from 1968
   assign q4 = p2_ff[32:27];
   assign r4 = dd_ff - 16'(q4) * 16'd1461;
   always_comb begin
      if (r4 < 16'd366) begin
         yoff = 2'd0;
      end else if (r4 < 16'd731) begin
         yoff = 2'd1;
      end else if (r4 < 16'd1096) begin
         yoff = 2'd2;
      end else begin
         yoff = 2'd3;
      end
   end
   assign n_in = {q4, 2'b00} + 8'(yoff);

   // stage 4: weekday of the base day
   assign p7_dst_in = 33'(d0_dst_ff[15:0] + 16'd4) * 33'(dstc_pkg::DIV7_MUL);
   assign p7_std_in = 33'(d0_std_ff[15:0] + 16'd4) * 33'(dstc_pkg::DIV7_MUL);

   // stage 6: change instants in seconds
   always_comb begin
      at_dst_in = 36'(dr_dst_ff) * 36'sd86400 + 36'(dst_rule_ff[14:10]) * 36'sd3600;
      at_std_in = 36'(dr_std_ff) * 36'sd86400 + 36'(std_rule_ff[14:10]) * 36'sd3600;
      if (!op_ff[5]) begin
         at_dst_in = at_dst_in - ssec;
         at_std_in = at_std_in - dsec;
      end
   end

   // stage 7: daylight decision and offset
   assign ti = 36'(signed'({4'b0000, t_ff[6]}));
   always_comb begin
      if (at_std_ff > at_dst_ff) begin
         in_dst_in = (ti >= at_dst_ff) && (ti < at_std_ff);
      end else begin
         in_dst_in = !((ti >= at_std_ff) && (ti < at_dst_ff));
      end
      off = in_dst_in ? dsec : ssec;
      time_out_in = op_ff[6] ? t_ff[6] - off[31:0] : t_ff[6] + off[31:0];
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         p1_ff <= p1_in;
      end
      if (en[1]) begin
         dd_ff <= dd_in;
         p2_ff <= p2_in;
      end
      if (en[2]) begin
         n_ff <= n_in;
      end
      if (en[3]) begin
         d0_dst_ff <= rule_base_day(dst_rule_ff, n_ff);
         d0_std_ff <= rule_base_day(std_rule_ff, n_ff);
      end
      if (en[4]) begin
         p7_dst_ff  <= p7_dst_in;
         p7_std_ff  <= p7_std_in;
         d0c_dst_ff <= d0_dst_ff;
         d0c_std_ff <= d0_std_ff;
      end
      if (en[5]) begin
         dr_dst_ff <= rule_day(dst_rule_ff, d0c_dst_ff, p7_dst_ff[32:19]);
         dr_std_ff <= rule_day(std_rule_ff, d0c_std_ff, p7_std_ff[32:19]);
      end
      if (en[6]) begin
         at_dst_ff <= at_dst_in;
         at_std_ff <= at_std_in;
      end
      if (en[7]) begin
         time_out_ff <= time_out_in;
         in_dst_ff   <= in_dst_in;
      end
   end

endmodule
`default_nettype wire

[sv/dstc_checker.sv]
// Port-level checker for the converter and its bind.
`default_nettype none
`include "dst_rule_time_converter_defines.svh"
module dstc_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire dstc_pkg::rsp_type rsp_data
);

   `DSTC_ASSERT_RST(a_empty_after_reset, clock, reset, !rsp_valid)
   `DSTC_ASSERT_IMP(a_ready_when_out_empty, clock, reset, !rsp_valid, req_ready)
   `DSTC_ASSERT_NXT(a_rsp_held, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `DSTC_ASSERT_NXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_data))

endmodule

bind dst_rule_time_converter dstc_checker u_dstc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
`default_nettype wire
